/* hw/rtl/dlf_pkg.sv */
// ----------------------------------------------------------------------------
// dlf_pkg
// Shared types and constants of the dense layer forward core: input action
// codes, activation modes, configuration register indexes and the tanh table.
// ----------------------------------------------------------------------------
package dlf_pkg;

    // fixed field widths
    localparam int ACTION_W = 2;
    localparam int ROW_W    = 6;
    localparam int UNIT_W   = 4;
    localparam int VALUE_W  = 16;
    localparam int ACC_W    = 40;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;

    // results per vector never exceed this many units
    localparam int RESULT_CAP = 16;

    // input item actions
    typedef enum logic [ACTION_W-1:0] {
        ACT_WEIGHT = 2'd0,
        ACT_BIAS   = 2'd1,
        ACT_ELEM   = 2'd2
    } t_action;

    // activation modes
    typedef enum logic [1:0] {
        MODE_LINEAR = 2'd0,
        MODE_TANH   = 2'd1,
        MODE_RELU   = 2'd2
    } t_mode;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ACT_MODE    = 2'd0,
        CFG_BIAS_EN     = 2'd1,
        CFG_INPUT_COUNT = 2'd2,
        CFG_UNIT_COUNT  = 2'd3
    } t_cfg_idx;

    // tanh(k/8) in Q8.8 for k = 0..32
    localparam int TANH_N = 33;
    localparam logic [8:0] TANH_TAB [0:TANH_N-1] = '{
        9'd0,   9'd32,  9'd63,  9'd92,  9'd118, 9'd142, 9'd163, 9'd180,
        9'd195, 9'd207, 9'd217, 9'd225, 9'd232, 9'd237, 9'd241, 9'd244,
        9'd247, 9'd249, 9'd250, 9'd252, 9'd253, 9'd253, 9'd254, 9'd254,
        9'd255, 9'd255, 9'd255, 9'd255, 9'd256, 9'd256, 9'd256, 9'd256,
        9'd256
    };

endpackage

/* hw/rtl/dense_layer_forward_core.sv */
// ----------------------------------------------------------------------------
// dense_layer_forward_core
// Fully connected layer forward pass in Q8.8 with one shared multiply-add,
// per-unit 40-bit accumulators and linear, tanh or relu activation.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one beat per item: a
//   weight load, a bias load or one input vector element. An element
//   occupies the shared multiplier while its weights for the nu units in
//   use are read from the weight RAM one unit per cycle through a
//   three-stage read, multiply, accumulate pipe. The element with index
//   input_count-1 then emits nu result beats on the output channel
//   (o_out_valid / i_out_ready) in unit order, the last one flagged by
//   o_last. Accumulators are then cleared. o_in_ready is low while an
//   element or its results are in progress; a single output register
//   holds a result while the receiver stalls, and the sequencer waits
//   on it.
//   Configuration beats (i_cfg_valid / o_cfg_ready) are always taken and
//   are to be written only while the block is idle.
//   Reset clears the accumulators and registers (linear, bias on, 64
//   inputs, 16 units); weight and bias RAM contents are undefined until
//   written.
// ----------------------------------------------------------------------------
module dense_layer_forward_core
    import dlf_pkg::*;
#(
    parameter int MAX_INPUTS = 64,
    parameter int MAX_UNITS  = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration channel
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // input channel
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [ACTION_W-1:0]   i_action,
    input  logic [ROW_W-1:0]      i_row_index,
    input  logic [UNIT_W-1:0]     i_unit_index,
    input  logic signed [VALUE_W-1:0] i_value,
    // output channel
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [UNIT_W-1:0]     o_out_unit,
    output logic signed [VALUE_W-1:0] o_activity,
    output logic                  o_saturated,
    output logic                  o_last
);

    localparam int UCAP    = (MAX_UNITS < RESULT_CAP) ? MAX_UNITS : RESULT_CAP;
    localparam int W_DEPTH = MAX_INPUTS * MAX_UNITS;
    localparam int W_AW    = (W_DEPTH > 1) ? $clog2(W_DEPTH) : 1;
    localparam int B_AW    = (MAX_UNITS > 1) ? $clog2(MAX_UNITS) : 1;
    localparam int B_DEPTH = 2 ** B_AW;

    // sequencer states
    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_MAC  = 6'b000010,
        S_RD   = 6'b000100,
        S_CALC = 6'b001000,
        S_ACT  = 6'b010000,
        S_OUT  = 6'b100000
    } t_state;

    t_state r_state, n_state;

    // configuration registers
    logic [1:0] r_act_mode;
    logic       r_bias_en;
    logic [6:0] r_in_count;
    logic [4:0] r_unit_count;

    // storage
    logic signed [VALUE_W-1:0] weight_mem [0:W_DEPTH-1];
    logic signed [VALUE_W-1:0] bias_mem   [0:B_DEPTH-1];
    logic signed [ACC_W-1:0]   r_acc      [0:RESULT_CAP-1];

    // latched element
    logic signed [VALUE_W-1:0] r_val;
    logic [ROW_W-1:0]          r_row;
    logic                      r_last_elem;
    logic [UNIT_W-1:0]         r_nu_m1;

    // multiply-accumulate pipe
    logic [UNIT_W-1:0]         r_iss;
    logic                      r_iss_done;
    logic                      r_p1_v, r_p2_v;
    logic [UNIT_W-1:0]         r_p1_u, r_p2_u;
    logic signed [VALUE_W-1:0] r_wq;
    logic signed [2*VALUE_W-1:0] r_prod;

    // result path
    logic [UNIT_W-1:0]         r_u;
    logic signed [ACC_W-1:0]   r_aq;
    logic signed [VALUE_W-1:0] r_bq;
    logic signed [VALUE_W-1:0] r_pre;
    logic                      r_pre_sat;
    logic signed [VALUE_W-1:0] r_act;

    // output register
    logic                      r_out_valid;
    logic [UNIT_W-1:0]         r_out_unit;
    logic signed [VALUE_W-1:0] r_out_act;
    logic                      r_out_sat;
    logic                      r_out_last;

    // weight address: row * MAX_UNITS + unit
    function automatic logic [W_AW-1:0] f_waddr(input logic [ROW_W-1:0] row,
                                                input logic [UNIT_W-1:0] unit);
        return W_AW'(32'(row) * MAX_UNITS + 32'(unit));
    endfunction

    // handshakes
    logic in_beat, cfg_beat, out_free;
    assign o_cfg_ready = 1'b1;
    assign cfg_beat    = i_cfg_valid;
    assign o_in_ready  = (r_state == S_IDLE);
    assign in_beat     = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;

    // counts in use
    logic [4:0] nu_n;
    logic [6:0] ni_n, ni_m1;
    always_comb begin
        nu_n = (r_unit_count == 5'd0) ? 5'd1 : r_unit_count;
        if (32'(nu_n) > UCAP) begin
            nu_n = 5'(UCAP);
        end
        ni_n = (r_in_count == 7'd0) ? 7'd1 : r_in_count;
        if (32'(ni_n) > MAX_INPUTS) begin
            ni_n = 7'(MAX_INPUTS);
        end
        ni_m1 = ni_n - 7'd1;
    end

    // decode of an accepted beat
    logic we_w, we_b, start_elem;
    always_comb begin
        we_w = 1'b0;
        we_b = 1'b0;
        start_elem = 1'b0;
        if (in_beat) begin
            case (i_action)
                ACT_WEIGHT: we_w = (32'(i_row_index) < MAX_INPUTS) &&
                                   (32'(i_unit_index) < MAX_UNITS);
                ACT_BIAS:   we_b = (32'(i_unit_index) < MAX_UNITS);
                ACT_ELEM:   start_elem = ({1'b0, i_row_index} <= ni_m1);
                default:    ;
            endcase
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act_mode   <= MODE_LINEAR;
            r_bias_en    <= 1'b1;
            r_in_count   <= 7'd64;
            r_unit_count <= 5'd16;
        end else if (cfg_beat) begin
            case (i_cfg_index)
                CFG_ACT_MODE:    r_act_mode   <= i_cfg_data[1:0];
                CFG_BIAS_EN:     r_bias_en    <= i_cfg_data[0];
                CFG_INPUT_COUNT: r_in_count   <= i_cfg_data[6:0];
                CFG_UNIT_COUNT:  r_unit_count <= i_cfg_data[4:0];
                default:         ;
            endcase
        end
    end

    // weight ram, read one unit per cycle
    always_ff @(posedge i_clk) begin
        if (we_w) begin
            weight_mem[f_waddr(i_row_index, i_unit_index)] <= i_value;
        end
        r_wq <= weight_mem[f_waddr(r_row, r_iss)];
    end

    // bias ram, read at the result unit
    always_ff @(posedge i_clk) begin
        if (we_b) begin
            bias_mem[B_AW'(i_unit_index)] <= i_value;
        end
        r_bq <= bias_mem[B_AW'(r_u)];
    end

    // element latch
    always_ff @(posedge i_clk) begin
        if (start_elem) begin
            r_val       <= i_value;
            r_row       <= i_row_index;
            r_last_elem <= ({1'b0, i_row_index} == ni_m1);
            r_nu_m1     <= 4'(nu_n - 5'd1);
        end
    end

    // issue counter
    logic issue;
    assign issue = (r_state == S_MAC) && !r_iss_done;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iss      <= '0;
            r_iss_done <= 1'b1;
        end else if (start_elem) begin
            r_iss      <= '0;
            r_iss_done <= 1'b0;
        end else if (issue) begin
            if (r_iss == r_nu_m1) begin
                r_iss_done <= 1'b1;
            end else begin
                r_iss <= r_iss + 4'd1;
            end
        end
    end

    // pipe valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_v <= 1'b0;
            r_p2_v <= 1'b0;
        end else begin
            r_p1_v <= issue;
            r_p2_v <= r_p1_v;
        end
    end

    // multiply stage
    always_ff @(posedge i_clk) begin
        r_p1_u <= r_iss;
        r_p2_u <= r_p1_u;
        r_prod <= r_wq * r_val;
    end

    // accumulate stage, cleared after the last result
    logic clear_acc;
    assign clear_acc = (r_state == S_OUT) && out_free && (r_u == r_nu_m1);
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || clear_acc) begin
            for (int k = 0; k < RESULT_CAP; k++) begin
                r_acc[k] <= '0;
            end
        end else if (r_p2_v) begin
            r_acc[r_p2_u] <= r_acc[r_p2_u] +
                             {{(ACC_W-2*VALUE_W){r_prod[2*VALUE_W-1]}}, r_prod};
        end
    end

    // round, bias and saturate
    logic [ACC_W:0]        sum;
    logic signed [32:0]    q;
    logic signed [VALUE_W-1:0] q_clip;
    logic                  q_sat;
    always_comb begin
        sum = {r_aq[ACC_W-1], r_aq} + 41'd128;
        if (r_bias_en) begin
            sum = sum + {{17{r_bq[VALUE_W-1]}}, r_bq, 8'd0};
        end
        q = $signed(sum[ACC_W:8]);
        q_sat = 1'b0;
        q_clip = q[VALUE_W-1:0];
        if (q > 33'sd32767) begin
            q_clip = 16'sh7fff;
            q_sat  = 1'b1;
        end else if (q < -33'sd32768) begin
            q_clip = 16'sh8000;
            q_sat  = 1'b1;
        end
    end

    // activation
    logic [16:0]  a_abs;
    logic [5:0]   t_idx;
    logic [4:0]   t_frac;
    logic [8:0]   t0, t1, t_y;
    logic [5:0]   t_d;
    logic [10:0]  t_mul;
    logic signed [VALUE_W-1:0] act_val;
    always_comb begin
        a_abs  = r_pre[VALUE_W-1] ? 17'(-{r_pre[VALUE_W-1], r_pre})
                                  : {1'b0, r_pre};
        t_idx  = {1'b0, a_abs[9:5]};
        t_frac = a_abs[4:0];
        t0     = TANH_TAB[t_idx];
        t1     = TANH_TAB[t_idx + 6'd1];
        t_d    = 6'(t1 - t0);
        t_mul  = 11'(t_d * t_frac) + 11'd16;
        t_y    = (a_abs >= 17'd1024) ? 9'd256 : t0 + {3'd0, t_mul[10:5]};
        case (r_act_mode)
            MODE_TANH: act_val = r_pre[VALUE_W-1] ? -$signed({7'd0, t_y})
                                                  : $signed({7'd0, t_y});
            MODE_RELU: act_val = r_pre[VALUE_W-1] ? '0 : r_pre;
            default:   act_val = r_pre;
        endcase
    end

    // result path registers
    always_ff @(posedge i_clk) begin
        r_aq <= r_acc[r_u];
        if (r_state == S_CALC) begin
            r_pre     <= q_clip;
            r_pre_sat <= q_sat;
        end
        if (r_state == S_ACT) begin
            r_act <= act_val;
        end
    end

    // result unit counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_u <= '0;
        end else if (start_elem) begin
            r_u <= '0;
        end else if ((r_state == S_OUT) && out_free && !clear_acc) begin
            r_u <= r_u + 4'd1;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_OUT) && out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if ((r_state == S_OUT) && out_free) begin
            r_out_unit <= r_u;
            r_out_act  <= r_act;
            r_out_sat  <= r_pre_sat;
            r_out_last <= (r_u == r_nu_m1);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_unit  = r_out_unit;
    assign o_activity  = r_out_act;
    assign o_saturated = r_out_sat;
    assign o_last      = r_out_last;

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (start_elem) n_state = S_MAC;
            S_MAC: begin
                if (r_iss_done && !r_p1_v && !r_p2_v) begin
                    n_state = r_last_elem ? S_RD : S_IDLE;
                end
            end
            S_RD:   n_state = S_CALC;
            S_CALC: n_state = S_ACT;
            S_ACT:  n_state = S_OUT;
            S_OUT: begin
                if (out_free) begin
                    n_state = clear_acc ? S_IDLE : S_RD;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

/* verif/tb_dense_layer_forward_core.sv */
// ----------------------------------------------------------------------------
// tb_dense_layer_forward_core
// Self-checking bench for the dense layer forward core. A Q8.8 layer
// predictor mirrors the weight, bias and accumulator state and the register
// settings. It builds the expected unit results of every closing vector
// element, and each result beat on the output channel is compared field by
// field with the oldest one. Stimulus runs through reset defaults,
// activation modes, count limits, accumulator wrap, output back-pressure
// and random well-formed vectors with injected noise.
// ----------------------------------------------------------------------------
module tb_dense_layer_forward_core;
    import dlf_pkg::*;

    localparam int MAX_INPUTS    = 64;
    localparam int MAX_UNITS     = 16;
    localparam int SETTLE_CYCLES = 32;
    localparam int CYCLE_LIMIT   = 500000;
    localparam int RANDOM_ITEMS  = 480;
    localparam int IDLE_PERCENT  = 13;

    // codes the package leaves unnamed
    localparam logic [ACTION_W-1:0] ACT_SPARE  = 2'd3;
    localparam logic [1:0]          MODE_SPARE = 2'd3;

    typedef struct {
        logic [UNIT_W-1:0]         unit;
        logic signed [VALUE_W-1:0] activity;
        logic                      saturated;
        logic                      last;
    } unit_result_t;

    // clock, reset and block ports
    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_cfg_valid = 1'b0;
    logic                          o_cfg_ready;
    logic [CFG_IDX_W-1:0]          i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]         i_cfg_data = '0;
    logic                          i_in_valid = 1'b0;
    logic                          o_in_ready;
    logic [ACTION_W-1:0]           i_action = '0;
    logic [ROW_W-1:0]              i_row_index = '0;
    logic [UNIT_W-1:0]             i_unit_index = '0;
    logic signed [VALUE_W-1:0]     i_value = '0;
    logic                          o_out_valid;
    logic                          i_out_ready = 1'b0;
    logic [UNIT_W-1:0]             o_out_unit;
    logic signed [VALUE_W-1:0]     o_activity;
    logic                          o_saturated;
    logic                          o_last;

    // layer mirror: stores, accumulators and register settings
    logic signed [VALUE_W-1:0]     weight_mirror [0:MAX_INPUTS*MAX_UNITS-1];
    logic signed [VALUE_W-1:0]     bias_mirror [0:MAX_UNITS-1];
    logic signed [ACC_W-1:0]       acc_mirror [0:MAX_UNITS-1];
    logic [1:0]                    mode_reg = MODE_LINEAR;
    logic                          bias_en_reg = 1'b1;
    logic [6:0]                    inputs_reg = 7'd64;
    logic [4:0]                    units_reg = 5'd16;
    unit_result_t                  expected_results [$];

    // tanh(k/8) in Q8.8, k = 0..32
    int tanh_pts [0:32] = '{
        0, 32, 63, 92, 118, 142, 163, 180, 195, 207, 217, 225, 232, 237, 241,
        244, 247, 249, 250, 252, 253, 253, 254, 254, 255, 255, 255, 255, 256,
        256, 256, 256, 256};

    // stimulus side bookkeeping
    bit  w_loaded [0:MAX_INPUTS*MAX_UNITS-1];
    bit  calm = 1'b0;
    int  out_hold_cycles = 0;
    int  items_sent = 0;
    int  gen_inputs = 64;
    int  gen_units = 16;
    int  mismatch_count = 0;
    int  cycle_count = 0;

    dense_layer_forward_core u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_action     (i_action),
        .i_row_index  (i_row_index),
        .i_unit_index (i_unit_index),
        .i_value      (i_value),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_unit   (o_out_unit),
        .o_activity   (o_activity),
        .o_saturated  (o_saturated),
        .o_last       (o_last)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // layer predictor
    // ------------------------------------------------------------------

    // counts as the block uses them
    function automatic int inputs_active(int n);
        if (n == 0) return 1;
        if (n > MAX_INPUTS) return MAX_INPUTS;
        return n;
    endfunction

    function automatic int units_active(int n);
        if (n == 0) return 1;
        if (n > MAX_UNITS) return MAX_UNITS;
        return n;
    endfunction

    // table tanh with interpolation over 1/256 steps, odd symmetric
    function automatic int tanh_q88(int x);
        int mag, idx, frac, slope, y;
        mag = (x < 0) ? -x : x;
        if (mag >= 1024) begin
            y = 256;
        end else begin
            idx   = mag >> 5;
            frac  = mag & 31;
            slope = tanh_pts[idx + 1] - tanh_pts[idx];
            y     = tanh_pts[idx] + ((slope * frac + 16) >>> 5);
        end
        return (x < 0) ? -y : y;
    endfunction

    function automatic void write_register(logic [CFG_IDX_W-1:0] idx,
                                           logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_ACT_MODE:    mode_reg = data[1:0];
            CFG_BIAS_EN:     bias_en_reg = data[0];
            CFG_INPUT_COUNT: inputs_reg = data;
            CFG_UNIT_COUNT:  units_reg = data[4:0];
            default: ;
        endcase
    endfunction

    // multiply-accumulate one element; the closing row emits every unit in use
    function automatic void take_element(logic [ROW_W-1:0] row,
                                         logic signed [VALUE_W-1:0] value);
        int           n_in, n_units, level;
        longint       prod, total, rounded;
        unit_result_t res;
        n_in    = inputs_active(inputs_reg);
        n_units = units_active(units_reg);
        if (row >= n_in) return;
        for (int u = 0; u < n_units; u++) begin
            prod = longint'(weight_mirror[row * MAX_UNITS + u]) * longint'(value);
            acc_mirror[u] = acc_mirror[u] + prod[ACC_W-1:0];
        end
        if (row != n_in - 1) return;
        for (int u = 0; u < n_units; u++) begin
            total = acc_mirror[u];
            if (bias_en_reg) total = total + longint'(bias_mirror[u]) * 256;
            rounded = (total + 128) >>> 8;
            res.saturated = 1'b0;
            if (rounded > 32767) begin
                rounded = 32767;
                res.saturated = 1'b1;
            end else if (rounded < -32768) begin
                rounded = -32768;
                res.saturated = 1'b1;
            end
            level = int'(rounded);
            if (mode_reg == MODE_TANH) level = tanh_q88(level);
            else if (mode_reg == MODE_RELU && level < 0) level = 0;
            res.unit     = UNIT_W'(u);
            res.activity = VALUE_W'(level);
            res.last     = (u == n_units - 1);
            expected_results.push_back(res);
        end
        foreach (acc_mirror[k]) acc_mirror[k] = '0;
    endfunction

    task automatic report_mismatch(string field, longint want, longint got);
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------
    // beat monitor: checks results, tracks accepted config and input beats
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : beat_monitor
        unit_result_t want;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: result beat with none expected: unit %0d activity %0d",
                             $time, o_out_unit, o_activity);
                    mismatch_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (o_out_unit !== want.unit)
                        report_mismatch("out_unit", want.unit, o_out_unit);
                    if (o_activity !== want.activity)
                        report_mismatch("activity", want.activity, o_activity);
                    if (o_saturated !== want.saturated)
                        report_mismatch("saturated", want.saturated, o_saturated);
                    if (o_last !== want.last)
                        report_mismatch("last", want.last, o_last);
                end
            end
            if (i_cfg_valid && o_cfg_ready) write_register(i_cfg_index, i_cfg_data);
            if (i_in_valid && o_in_ready) begin
                case (i_action)
                    ACT_WEIGHT: weight_mirror[i_row_index * MAX_UNITS + i_unit_index] = i_value;
                    ACT_BIAS:   bias_mirror[i_unit_index] = i_value;
                    ACT_ELEM:   take_element(i_row_index, i_value);
                    default: ;
                endcase
            end
        end
    end

    // output receiver: random stalls, or a long hold-off when requested
    always @(posedge i_clk) begin
        if (out_hold_cycles > 0) begin
            out_hold_cycles--;
            i_out_ready <= 1'b0;
        end else if (calm) begin
            i_out_ready <= 1'b1;
        end else begin
            i_out_ready <= ($urandom_range(0, 99) >= IDLE_PERCENT);
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL dense_layer_forward_core");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    // Q8.8 value: mostly near unity, some wide, some extreme
    function automatic logic signed [VALUE_W-1:0] rand_q88();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 60) return VALUE_W'(int'($urandom_range(0, 800)) - 400);
        if (pick < 75) return VALUE_W'(int'($urandom_range(0, 4000)) - 2000);
        if (pick < 90) return VALUE_W'($urandom);
        case ($urandom_range(0, 4))
            0:       return 16'sh8000;
            1:       return 16'sh7fff;
            2:       return 16'sh0000;
            3:       return -16'sd1;
            default: return 16'sd1;
        endcase
    endfunction

    // one input beat, with an optional idle gap before it
    task automatic send_item(input logic [ACTION_W-1:0] action, input logic [ROW_W-1:0] row,
                             input logic [UNIT_W-1:0] unit,
                             input logic signed [VALUE_W-1:0] value);
        int gap;
        gap = 0;
        if (!calm && $urandom_range(0, 99) < IDLE_PERCENT) gap = $urandom_range(1, 4);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_action     <= action;
        i_row_index  <= row;
        i_unit_index <= unit;
        i_value      <= value;
        do @(posedge i_clk); while (!o_in_ready);
        items_sent++;
    endtask

    task automatic load_weight(input logic [ROW_W-1:0] row, input logic [UNIT_W-1:0] unit,
                               input logic signed [VALUE_W-1:0] value);
        send_item(ACT_WEIGHT, row, unit, value);
        w_loaded[row * MAX_UNITS + unit] = 1'b1;
    endtask

    task automatic send_element(input logic [ROW_W-1:0] row,
                                input logic signed [VALUE_W-1:0] value);
        send_item(ACT_ELEM, row, UNIT_W'($urandom), value);
    endtask

    // make sure every unit in use has a weight for this row
    task automatic prepare_row(input int row);
        for (int u = 0; u < gen_units; u++)
            if (!w_loaded[row * MAX_UNITS + u])
                load_weight(ROW_W'(row), UNIT_W'(u), rand_q88());
    endtask

    // beats that add no element to a vector in flight
    task automatic send_noise();
        case ($urandom_range(0, 3))
            0: send_item(ACT_SPARE, ROW_W'($urandom), UNIT_W'($urandom), rand_q88());
            1: if (gen_inputs < MAX_INPUTS)
                   send_element(ROW_W'($urandom_range(gen_inputs, MAX_INPUTS - 1)),
                                rand_q88());
            2: load_weight(ROW_W'($urandom), UNIT_W'($urandom), rand_q88());
            default: send_item(ACT_BIAS, ROW_W'($urandom), UNIT_W'($urandom), rand_q88());
        endcase
    endtask

    // one vector: shuffled rows, closing row last; noisy ones may drop,
    // repeat or never close
    task automatic run_vector(input bit noisy);
        int rows [$];
        int pick, tmp, final_row;
        final_row = gen_inputs - 1;
        for (int r = 0; r < final_row; r++) rows.push_back(r);
        for (int k = rows.size() - 1; k > 0; k--) begin
            pick = $urandom_range(0, k);
            tmp = rows[k];
            rows[k] = rows[pick];
            rows[pick] = tmp;
        end
        if (noisy && rows.size() > 0 && $urandom_range(0, 2) == 0)
            rows.delete($urandom_range(0, rows.size() - 1));
        if (noisy && rows.size() > 0 && $urandom_range(0, 2) == 0)
            rows.push_back(rows[$urandom_range(0, rows.size() - 1)]);
        foreach (rows[k]) begin
            if (noisy && $urandom_range(0, 5) == 0) send_noise();
            prepare_row(rows[k]);
            send_element(ROW_W'(rows[k]), rand_q88());
        end
        if (noisy && $urandom_range(0, 9) == 0) return;
        prepare_row(final_row);
        send_element(ROW_W'(final_row), rand_q88());
    endtask

    task automatic cfg_beat(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    // all four registers, unused data bits random; only while idle
    task automatic configure(input logic [1:0] mode, input logic bias_on,
                             input logic [6:0] inputs_w, input logic [6:0] units_w);
        cfg_beat(CFG_ACT_MODE, {5'($urandom), mode});
        cfg_beat(CFG_BIAS_EN, {6'($urandom), bias_on});
        cfg_beat(CFG_INPUT_COUNT, inputs_w);
        cfg_beat(CFG_UNIT_COUNT, units_w);
        i_cfg_valid <= 1'b0;
        gen_inputs = inputs_active(inputs_w);
        gen_units  = units_active(units_w[4:0]);
    endtask

    // stop sending, wait out every expected result, then let the pipe settle
    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (expected_results.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // reset settings: linear, bias on, 64 inputs, 16 units; extreme words
    task automatic test_reset_defaults();
        send_item(ACT_BIAS, '0, 4'd0, 16'sh7fff);
        send_item(ACT_BIAS, '1, 4'd1, 16'sh8000);
        send_item(ACT_BIAS, '0, 4'd2, 16'sh0000);
        send_item(ACT_BIAS, '1, 4'd3, -16'sd1);
        for (int u = 4; u < MAX_UNITS; u++)
            send_item(ACT_BIAS, ROW_W'($urandom), UNIT_W'(u), rand_q88());
        load_weight(6'd63, 4'd0, 16'sh7fff);
        load_weight(6'd63, 4'd1, 16'sh8000);
        load_weight(6'd63, 4'd2, 16'sh8000);
        load_weight(6'd63, 4'd3, 16'sd1);
        prepare_row(63);
        send_element(6'd63, 16'sh8000);
        drain();
    endtask

    // every activation code with bias off and on, plus ignored beats
    task automatic test_activation_modes();
        logic [1:0] modes [4] = '{MODE_LINEAR, MODE_TANH, MODE_RELU, MODE_SPARE};
        for (int m = 0; m < 4; m++) begin
            for (int b = 0; b < 2; b++) begin
                configure(modes[m], b[0], 7'd2, 7'd4);
                run_vector(1'b0);
                drain();
            end
        end
        // unused action, element beyond count, repeated row
        send_item(ACT_SPARE, 6'd1, 4'd5, 16'sh7fff);
        send_element(6'd5, 16'sh4000);
        send_element(6'd0, 16'sh0180);
        send_element(6'd0, -16'sh0100);
        send_element(6'd1, 16'sh0080);
        drain();
    endtask

    // counts of zero and above the block's size
    task automatic test_count_limits();
        configure(MODE_LINEAR, 1'b1, 7'd0, 7'd0);
        run_vector(1'b0);
        run_vector(1'b0);
        drain();
        configure(MODE_TANH, 1'b1, 7'd127, 7'd31);
        prepare_row(0);
        send_element(6'd0, rand_q88());
        send_element(6'd63, rand_q88());
        drain();
        configure(MODE_RELU, 1'b0, 7'd64, 7'd16);
        prepare_row(62);
        send_element(6'd62, rand_q88());
        send_element(6'd63, rand_q88());
        drain();
        configure(MODE_LINEAR, 1'b1, 7'd65, 7'd17);
        send_element(6'd63, rand_q88());
        drain();
        configure(MODE_TANH, 1'b0, 7'd1, 7'd1);
        run_vector(1'b0);
        run_vector(1'b0);
        drain();
    endtask

    // repeated maximum products push both accumulators past 40 bits
    task automatic test_accumulator_wrap();
        configure(MODE_LINEAR, 1'b0, 7'd2, 7'd2);
        calm = 1'b1;
        load_weight(6'd0, 4'd0, 16'sh8000);
        load_weight(6'd0, 4'd1, 16'sh7fff);
        prepare_row(1);
        repeat (520) send_element(6'd0, 16'sh8000);
        send_element(6'd1, rand_q88());
        calm = 1'b0;
        drain();
    endtask

    // receiver holds off while vectors keep coming, so the input stalls
    task automatic test_backpressure();
        configure(MODE_RELU, 1'b1, 7'd2, 7'd16);
        out_hold_cycles = 400;
        repeat (6) run_vector(1'b0);
        drain();
    endtask

    // random phases of random settings; mostly clean vectors, some noisy
    task automatic test_random_traffic();
        int         start, phase, phase_end, pick;
        logic [6:0] inputs_w;
        logic [4:0] units_w;
        start = items_sent;
        phase = 0;
        while (items_sent - start < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 60)      inputs_w = 7'($urandom_range(1, 6));
            else if (pick < 70) inputs_w = 7'd0;
            else if (pick < 85) inputs_w = 7'($urandom_range(7, 24));
            else if (pick < 95) inputs_w = 7'($urandom_range(25, 64));
            else                inputs_w = 7'($urandom_range(65, 127));
            pick = $urandom_range(0, 99);
            if (pick < 70)      units_w = 5'($urandom_range(1, 16));
            else if (pick < 80) units_w = 5'd0;
            else                units_w = 5'($urandom_range(17, 31));
            configure(2'($urandom), 1'($urandom), inputs_w, {2'($urandom), units_w});
            // every fourth phase runs without any idling
            calm = (phase % 4 == 1);
            phase_end = items_sent + $urandom_range(30, 70);
            while (items_sent < phase_end) run_vector($urandom_range(0, 3) == 0);
            calm = 1'b0;
            drain();
            phase++;
        end
    endtask

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------
    initial begin
        foreach (acc_mirror[k]) acc_mirror[k] = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_defaults();
        test_activation_modes();
        test_count_limits();
        test_accumulator_wrap();
        test_backpressure();
        test_random_traffic();
        if (mismatch_count == 0)
            $display("PASS dense_layer_forward_core");
        else
            $display("FAIL dense_layer_forward_core");
        $finish;
    end

endmodule
